/* src/vna_pkg.sv */
// Package for the vertex normal accumulator: widths, datapath command codes
// and the command and status structs shared by the controller and datapath.
// No dependencies.
package vna_pkg;

   localparam int VERTEX_COUNT = 1024;
   localparam int INDEX_BITS   = 10;
   localparam int ADDR_BITS    = 10;
   localparam int COORD_BITS   = 24;
   localparam int ACC_BITS     = 24;
   localparam int FRAC_BITS    = 14;
   localparam int NORM_BITS    = 16;

   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_LIMIT  = 30;
   localparam int SQ_BITS    = 2 * MAG_LIMIT;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int BIT_BITS   = SUM_BITS + 1;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int NUM_BITS   = MAG_LIMIT + FRAC_BITS + 1;
   localparam int SQRT_STEPS = BIT_BITS / 2 + 1;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_TRI  = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;
   localparam logic [1:0] ACT_NOP  = 2'd3;

   localparam logic [4:0] OP_NONE      = 5'd0;
   localparam logic [4:0] OP_CLEAR     = 5'd1;
   localparam logic [4:0] OP_ACCEPT    = 5'd2;
   localparam logic [4:0] OP_LOAD_WR   = 5'd3;
   localparam logic [4:0] OP_POS_RD    = 5'd4;
   localparam logic [4:0] OP_EDGE      = 5'd5;
   localparam logic [4:0] OP_CROSS     = 5'd6;
   localparam logic [4:0] OP_ACC_CAP   = 5'd7;
   localparam logic [4:0] OP_NORM_INIT = 5'd8;
   localparam logic [4:0] OP_SHIFT     = 5'd9;
   localparam logic [4:0] OP_SQ        = 5'd10;
   localparam logic [4:0] OP_SQRT_INIT = 5'd11;
   localparam logic [4:0] OP_SQRT_ITER = 5'd12;
   localparam logic [4:0] OP_DIV_INIT  = 5'd13;
   localparam logic [4:0] OP_DIV_ITER  = 5'd14;
   localparam logic [4:0] OP_DIV_DONE  = 5'd15;
   localparam logic [4:0] OP_ACC_RD    = 5'd16;
   localparam logic [4:0] OP_ACC_WR    = 5'd17;
   localparam logic [4:0] OP_OUT       = 5'd18;

   typedef struct packed {
      logic [4:0]           op;
      logic [2:0]           sel;
      logic [ADDR_BITS-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic       zero;
      logic       big;
      logic       a_ok;
      logic       tri_ok;
      logic [1:0] action;
   } status_type;

endpackage

/* src/vna_datapath.sv */
// Datapath of the vertex normal accumulator: position and accumulator
// memories, cross product, normalization (shift, squares, root, divide).
// Depends on vna_pkg.
module vna_datapath (
   input  logic                               clock,
   input  vna_pkg::cmd_type                   cmd,
   output vna_pkg::status_type                status,
   input  logic [1:0]                         req_action,
   input  logic [vna_pkg::INDEX_BITS-1:0]     req_index_a,
   input  logic [vna_pkg::INDEX_BITS-1:0]     req_index_b,
   input  logic [vna_pkg::INDEX_BITS-1:0]     req_index_c,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_vertex_x,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_vertex_y,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_vertex_z,
   output logic [vna_pkg::INDEX_BITS-1:0]     rsp_vertex_index,
   output logic signed [vna_pkg::NORM_BITS-1:0] rsp_normal_x,
   output logic signed [vna_pkg::NORM_BITS-1:0] rsp_normal_y,
   output logic signed [vna_pkg::NORM_BITS-1:0] rsp_normal_z,
   output logic                               rsp_is_zero
);

   localparam int CB = vna_pkg::COORD_BITS;
   localparam int AB = vna_pkg::ACC_BITS;
   localparam int EB = vna_pkg::EDGE_BITS;
   localparam int PB = vna_pkg::PROD_BITS;
   localparam int XB = vna_pkg::CROSS_BITS;
   localparam int ML = vna_pkg::MAG_LIMIT;
   localparam int QB = vna_pkg::QUO_BITS;
   localparam int RB = vna_pkg::ROOT_BITS;
   localparam int FB = vna_pkg::FRAC_BITS;
   localparam int NB = vna_pkg::NORM_BITS;
   localparam int DB = vna_pkg::ADDR_BITS;

   logic signed [CB-1:0] pos_x_mem [vna_pkg::VERTEX_COUNT];
   logic signed [CB-1:0] pos_y_mem [vna_pkg::VERTEX_COUNT];
   logic signed [CB-1:0] pos_z_mem [vna_pkg::VERTEX_COUNT];
   logic signed [AB-1:0] acc_x_mem [vna_pkg::VERTEX_COUNT];
   logic signed [AB-1:0] acc_y_mem [vna_pkg::VERTEX_COUNT];
   logic signed [AB-1:0] acc_z_mem [vna_pkg::VERTEX_COUNT];

   logic [1:0]                      action_ff;
   logic [vna_pkg::INDEX_BITS-1:0]  ia_ff, ib_ff, ic_ff;
   logic signed [CB-1:0]            vx_ff, vy_ff, vz_ff;
   logic signed [CB-1:0]            pos_rd_ff [3];
   logic signed [AB-1:0]            acc_rd_ff [3];
   logic signed [CB-1:0]            pa_ff [3];
   logic signed [CB-1:0]            pb_ff [3];
   logic signed [EB-1:0]            e1_ff [3];
   logic signed [EB-1:0]            e2_ff [3];
   logic signed [PB-1:0]            prod_ff;
   logic signed [XB-1:0]            vec_ff [3];
   logic [XB-1:0]                   mag_ff [3];
   logic [2:0]                      neg_ff;
   logic                            zero_ff;
   logic [vna_pkg::SQ_BITS-1:0]     sq_ff;
   logic [vna_pkg::SUM_BITS-1:0]    sum_ff;
   logic [vna_pkg::BIT_BITS-1:0]    res_ff, bit_ff;
   logic [RB-1:0]                   len_ff;
   logic [RB-1:0]                   rem_ff;
   logic [QB-1:0]                   num_ff, quo_ff;
   logic signed [NB-1:0]            nrm_ff [3];

   logic [DB-1:0]                   corner;
   logic                            a_ok, tri_ok;
   logic [1:0]                      csel;
   logic [1:0]                      dsel;
   logic [1:0]                      vsel;
   logic signed [EB-1:0]            mul_a, mul_b;
   logic [XB-1:0]                   mag_in [3];
   logic [vna_pkg::BIT_BITS-1:0]    trial;
   logic [vna_pkg::NUM_BITS-1:0]    num_full;
   logic [RB:0]                     div_t;
   logic [QB-1:0]                   quo_cap;
   logic signed [AB:0]              sat_sum [3];
   logic signed [AB-1:0]            sat_out [3];
   logic                            acc_we;
   logic [DB-1:0]                   acc_wa;

   assign csel = cmd.sel[1:0];
   // A divide setup names its component one above the component index.
   assign dsel = 2'(cmd.sel - 3'd1);
   assign vsel = 2'((cmd.sel - 3'd1) >> 1);

   always_comb begin
      unique case (csel)
         2'd0:    corner = ia_ff[DB-1:0];
         2'd1:    corner = ib_ff[DB-1:0];
         default: corner = ic_ff[DB-1:0];
      endcase
   end

   assign a_ok   = 32'(ia_ff) < vna_pkg::VERTEX_COUNT;
   assign tri_ok = a_ok && (32'(ib_ff) < vna_pkg::VERTEX_COUNT)
                   && (32'(ic_ff) < vna_pkg::VERTEX_COUNT);

   assign status.zero   = zero_ff;
   assign status.big    = (mag_ff[0] >> ML) != '0 || (mag_ff[1] >> ML) != '0
                          || (mag_ff[2] >> ML) != '0;
   assign status.a_ok   = a_ok;
   assign status.tri_ok = tri_ok;
   assign status.action = action_ff;

   // Cross product terms in order: y*z, z*y, z*x, x*z, x*y, y*x.
   always_comb begin
      unique case (cmd.sel)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         default: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_ff[i][XB-1] ? XB'(-vec_ff[i]) : XB'(vec_ff[i]);
         sat_sum[i] = (AB+1)'(acc_rd_ff[i]) + (AB+1)'(nrm_ff[i]);
         if (sat_sum[i][AB] != sat_sum[i][AB-1])
            sat_out[i] = sat_sum[i][AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
         else
            sat_out[i] = sat_sum[i][AB-1:0];
      end
   end

   assign trial    = res_ff + bit_ff;
   assign num_full = {mag_ff[dsel][ML-1:0], {FB{1'b0}}}
                     + vna_pkg::NUM_BITS'(len_ff >> 1);
   assign div_t    = {rem_ff, num_ff[QB-1]};
   assign quo_cap  = (quo_ff > QB'(1 << FB)) ? QB'(1 << FB) : quo_ff;

   // Memories.
   always_comb begin
      acc_we = 1'b0;
      acc_wa = corner;
      priority case (cmd.op)
         vna_pkg::OP_CLEAR:   begin acc_we = 1'b1; acc_wa = cmd.addr; end
         vna_pkg::OP_LOAD_WR: begin acc_we = a_ok; acc_wa = ia_ff[DB-1:0]; end
         vna_pkg::OP_ACC_WR:  acc_we = 1'b1;
         default:             acc_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      pos_rd_ff[0] <= pos_x_mem[corner];
      pos_rd_ff[1] <= pos_y_mem[corner];
      pos_rd_ff[2] <= pos_z_mem[corner];
      acc_rd_ff[0] <= acc_x_mem[corner];
      acc_rd_ff[1] <= acc_y_mem[corner];
      acc_rd_ff[2] <= acc_z_mem[corner];
      if (cmd.op == vna_pkg::OP_LOAD_WR && a_ok) begin
         pos_x_mem[ia_ff[DB-1:0]] <= vx_ff;
         pos_y_mem[ia_ff[DB-1:0]] <= vy_ff;
         pos_z_mem[ia_ff[DB-1:0]] <= vz_ff;
      end
      if (acc_we) begin
         acc_x_mem[acc_wa] <= (cmd.op == vna_pkg::OP_ACC_WR) ? sat_out[0] : '0;
         acc_y_mem[acc_wa] <= (cmd.op == vna_pkg::OP_ACC_WR) ? sat_out[1] : '0;
         acc_z_mem[acc_wa] <= (cmd.op == vna_pkg::OP_ACC_WR) ? sat_out[2] : '0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         vna_pkg::OP_ACCEPT: begin
            action_ff <= req_action;
            ia_ff <= req_index_a;
            ib_ff <= req_index_b;
            ic_ff <= req_index_c;
            vx_ff <= req_vertex_x;
            vy_ff <= req_vertex_y;
            vz_ff <= req_vertex_z;
         end
         vna_pkg::OP_POS_RD: begin
            if (cmd.sel == 3'd1) pa_ff <= pos_rd_ff;
            if (cmd.sel == 3'd2) pb_ff <= pos_rd_ff;
         end
         vna_pkg::OP_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= EB'(pb_ff[i]) - EB'(pa_ff[i]);
               e2_ff[i] <= EB'(pos_rd_ff[i]) - EB'(pa_ff[i]);
            end
         end
         vna_pkg::OP_CROSS: begin
            // A product is formed one step and folded in the next.
            if (cmd.sel != 3'd6) prod_ff <= mul_a * mul_b;
            if (cmd.sel != 3'd0) begin
               if (cmd.sel[0])
                  vec_ff[vsel] <= XB'(prod_ff);
               else
                  vec_ff[vsel] <= vec_ff[vsel] - XB'(prod_ff);
            end
         end
         vna_pkg::OP_ACC_CAP: begin
            for (int i = 0; i < 3; i++)
               vec_ff[i] <= a_ok ? XB'(acc_rd_ff[i]) : '0;
         end
         vna_pkg::OP_NORM_INIT: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_in[i];
               neg_ff[i] <= vec_ff[i][XB-1];
               nrm_ff[i] <= '0;
            end
            zero_ff <= vec_ff[0] == '0 && vec_ff[1] == '0 && vec_ff[2] == '0;
         end
         vna_pkg::OP_SHIFT: begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end
         vna_pkg::OP_SQ: begin
            if (cmd.sel != 3'd3) sq_ff <= mag_ff[csel][ML-1:0] * mag_ff[csel][ML-1:0];
            if (cmd.sel == 3'd0) sum_ff <= '0;
            else sum_ff <= sum_ff + vna_pkg::SUM_BITS'(sq_ff);
         end
         vna_pkg::OP_SQRT_INIT: begin
            res_ff <= '0;
            bit_ff <= vna_pkg::BIT_BITS'(1) << (vna_pkg::BIT_BITS - 1);
         end
         vna_pkg::OP_SQRT_ITER: begin
            if (vna_pkg::BIT_BITS'(sum_ff) >= trial) begin
               sum_ff <= sum_ff - vna_pkg::SUM_BITS'(trial);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            len_ff <= (res_ff == '0 && bit_ff == '0) ? RB'(1) : len_ff;
         end
         vna_pkg::OP_DIV_INIT: begin
            if (cmd.sel == 3'd0)
               len_ff <= (res_ff[RB-1:0] == '0) ? RB'(1) : res_ff[RB-1:0];
            else begin
               rem_ff <= RB'(num_full >> QB);
               num_ff <= num_full[QB-1:0];
            end
            quo_ff <= '0;
         end
         vna_pkg::OP_DIV_ITER: begin
            if (div_t >= {1'b0, len_ff}) begin
               rem_ff <= RB'(div_t - {1'b0, len_ff});
               quo_ff <= {quo_ff[QB-2:0], 1'b1};
            end else begin
               rem_ff <= div_t[RB-1:0];
               quo_ff <= {quo_ff[QB-2:0], 1'b0};
            end
            num_ff <= {num_ff[QB-2:0], 1'b0};
         end
         vna_pkg::OP_DIV_DONE: begin
            nrm_ff[csel] <= neg_ff[csel] ? -NB'(quo_cap) : NB'(quo_cap);
         end
         vna_pkg::OP_OUT: begin
            rsp_vertex_index <= ia_ff;
            rsp_normal_x <= nrm_ff[0];
            rsp_normal_y <= nrm_ff[1];
            rsp_normal_z <= nrm_ff[2];
            rsp_is_zero <= zero_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

/* src/vna_ctrl.sv */
// Controller of the vertex normal accumulator: sequences the clearing pass
// and each word's steps, and holds the handshake state. Depends on vna_pkg.
module vna_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  vna_pkg::status_type status,
   output vna_pkg::cmd_type    cmd
);

   localparam logic [4:0] S_CLEAR     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_LOAD      = 5'd2;
   localparam logic [4:0] S_TRI_RD    = 5'd3;
   localparam logic [4:0] S_EDGE      = 5'd4;
   localparam logic [4:0] S_CROSS     = 5'd5;
   localparam logic [4:0] S_RD_A      = 5'd6;
   localparam logic [4:0] S_RD_CAP    = 5'd7;
   localparam logic [4:0] S_NORM      = 5'd8;
   localparam logic [4:0] S_SHIFT     = 5'd9;
   localparam logic [4:0] S_SQ        = 5'd10;
   localparam logic [4:0] S_SQRT_INIT = 5'd11;
   localparam logic [4:0] S_SQRT      = 5'd12;
   localparam logic [4:0] S_LEN       = 5'd13;
   localparam logic [4:0] S_DIV_INIT  = 5'd14;
   localparam logic [4:0] S_DIV       = 5'd15;
   localparam logic [4:0] S_DIV_DONE  = 5'd16;
   localparam logic [4:0] S_FINISH    = 5'd17;
   localparam logic [4:0] S_ACC_RD    = 5'd18;
   localparam logic [4:0] S_ACC_WR    = 5'd19;
   localparam logic [4:0] S_OUT       = 5'd20;

   logic [4:0]                     state_ff, state_in;
   logic [5:0]                     cnt_ff, cnt_in;
   logic [1:0]                     idx_ff, idx_in;
   logic [vna_pkg::ADDR_BITS-1:0]  clr_ff, clr_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      clr_in   = clr_ff;
      cmd.op   = vna_pkg::OP_NONE;
      cmd.sel  = '0;
      cmd.addr = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = vna_pkg::OP_CLEAR;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == vna_pkg::VERTEX_COUNT - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = vna_pkg::OP_ACCEPT;
               cnt_in = '0;
               idx_in = '0;
               state_in = S_TRI_RD;
            end
         end
         S_LOAD: begin
            cmd.op = vna_pkg::OP_LOAD_WR;
            state_in = S_IDLE;
         end
         S_TRI_RD: begin
            // Dispatch happens here, in the cycle after the word is latched.
            if (cnt_ff == '0 && status.action != vna_pkg::ACT_TRI) begin
               unique case (status.action)
                  vna_pkg::ACT_LOAD: state_in = S_LOAD;
                  vna_pkg::ACT_READ: state_in = S_RD_A;
                  default:           state_in = S_IDLE;
               endcase
            end else if (cnt_ff == '0 && !status.tri_ok) begin
               state_in = S_IDLE;
            end else begin
               cmd.op  = vna_pkg::OP_POS_RD;
               cmd.sel = 3'(cnt_ff);
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == 6'd2) state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            cmd.op = vna_pkg::OP_EDGE;
            cnt_in = '0;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            cmd.op  = vna_pkg::OP_CROSS;
            cmd.sel = 3'(cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 6'd6) state_in = S_NORM;
         end
         S_RD_A: begin
            cmd.op  = vna_pkg::OP_ACC_RD;
            state_in = S_RD_CAP;
         end
         S_RD_CAP: begin
            cmd.op = vna_pkg::OP_ACC_CAP;
            state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op = vna_pkg::OP_NORM_INIT;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            cnt_in = '0;
            if (status.zero) state_in = S_FINISH;
            else if (status.big) cmd.op = vna_pkg::OP_SHIFT;
            else state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op  = vna_pkg::OP_SQ;
            cmd.sel = 3'(cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 6'd3) state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.op = vna_pkg::OP_SQRT_INIT;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = vna_pkg::OP_SQRT_ITER;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == vna_pkg::SQRT_STEPS - 1) state_in = S_LEN;
         end
         S_LEN: begin
            cmd.op  = vna_pkg::OP_DIV_INIT;
            cmd.sel = '0;
            idx_in  = '0;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op  = vna_pkg::OP_DIV_INIT;
            cmd.sel = {1'b0, idx_ff} + 3'd1;
            cnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = vna_pkg::OP_DIV_ITER;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == vna_pkg::QUO_BITS - 1) state_in = S_DIV_DONE;
         end
         S_DIV_DONE: begin
            cmd.op  = vna_pkg::OP_DIV_DONE;
            cmd.sel = {1'b0, idx_ff};
            idx_in  = idx_ff + 1'b1;
            state_in = (idx_ff == 2'd2) ? S_FINISH : S_DIV_INIT;
         end
         S_FINISH: begin
            idx_in = '0;
            state_in = (status.action == vna_pkg::ACT_READ) ? S_OUT : S_ACC_RD;
         end
         S_ACC_RD: begin
            cmd.op  = vna_pkg::OP_ACC_RD;
            cmd.sel = {1'b0, idx_ff};
            state_in = S_ACC_WR;
         end
         S_ACC_WR: begin
            cmd.op  = vna_pkg::OP_ACC_WR;
            cmd.sel = {1'b0, idx_ff};
            idx_in  = idx_ff + 1'b1;
            state_in = (idx_ff == 2'd2) ? S_IDLE : S_ACC_RD;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = vna_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/vertex_normal_accumulator.sv */
// Vertex normal accumulator: per-vertex averaging of unit face normals.
// After reset a clearing pass zeroes all 1024 accumulator entries; no word
// is accepted during it. Words are taken one at a time. A read also waits
// for the previous result word to be taken. Normalizing a non-zero sum
// takes up to 19 scaling shifts, the 32-step root and three 15-step divides.
module vertex_normal_accumulator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [vna_pkg::INDEX_BITS-1:0]        req_index_a,
   input  logic [vna_pkg::INDEX_BITS-1:0]        req_index_b,
   input  logic [vna_pkg::INDEX_BITS-1:0]        req_index_c,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_vertex_x,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_vertex_y,
   input  logic signed [vna_pkg::COORD_BITS-1:0] req_vertex_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vna_pkg::INDEX_BITS-1:0]        rsp_vertex_index,
   output logic signed [vna_pkg::NORM_BITS-1:0]  rsp_normal_x,
   output logic signed [vna_pkg::NORM_BITS-1:0]  rsp_normal_y,
   output logic signed [vna_pkg::NORM_BITS-1:0]  rsp_normal_z,
   output logic                                  rsp_is_zero
);

   vna_pkg::cmd_type    cmd;
   vna_pkg::status_type status;

   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vna_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_index_a      (req_index_a),
      .req_index_b      (req_index_b),
      .req_index_c      (req_index_c),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_vertex_z     (req_vertex_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_is_zero      (rsp_is_zero)
   );

endmodule
